// ----- hdl/byte_histogram_sorted_unit_assert.svh -----
// ----------------------------------------------------------------------------
// byte histogram sorted unit assertion macros
// shared property wrappers for the port checker, clocked on clk and
// disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BYTE_HISTOGRAM_SORTED_UNIT_ASSERT_SVH
`define BYTE_HISTOGRAM_SORTED_UNIT_ASSERT_SVH

// same-cycle implication
`define BHS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BHS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bhs_pkg.sv -----
// ----------------------------------------------------------------------------
// bhs_pkg
// shared widths, action codes, scan control type and key mapping for the
// byte histogram sorted unit
// ----------------------------------------------------------------------------
`default_nettype none

package bhs_pkg;

    // fixed field widths
    localparam int ACTION_W = 2;
    localparam int SYM_W    = 8;
    localparam int FREQ_W   = 32;
    localparam int DIST_W   = 9;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COUNT  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

    // flipping the top bit turns a byte into its signed-char order key
    localparam logic [SYM_W-1:0] KEY_FLIP = 8'h80;

    // control from the sequencer to the rank unit
    typedef struct packed {
        logic             start;
        logic             sample;
        logic [SYM_W-1:0] t_key;
    } scan_ctl_t;

    // symbol to tie-break key and back (the map is its own inverse)
    function automatic logic [SYM_W-1:0] sym_key(input logic [SYM_W-1:0] s);
        return s ^ KEY_FLIP;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bhs_ram.sv -----
// ----------------------------------------------------------------------------
// bhs_ram
// generic single-write, single-read synchronous ram with registered read
// data that holds while no read is issued
// ----------------------------------------------------------------------------
`default_nettype none

module bhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/bhs_rank_unit.sv -----
// ----------------------------------------------------------------------------
// bhs_rank_unit
// accumulates the sorted position of one symbol while the bins stream past:
// counts bins that are smaller, or equal with a lower tie-break key
// ----------------------------------------------------------------------------
`default_nettype none

module bhs_rank_unit #(
    parameter int COUNT_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bhs_pkg::scan_ctl_t          ctl,
    input  logic [COUNT_BITS-1:0]       t_count,
    input  logic [COUNT_BITS-1:0]       s_count,
    input  logic [bhs_pkg::SYM_W-1:0]   s_key,
    output logic [bhs_pkg::DIST_W-1:0]  rank
);
    import bhs_pkg::*;

    logic [DIST_W-1:0] rank_reg;
    logic [DIST_W-1:0] rank_next;
    logic              ahead;

    // does the streamed bin sort ahead of the held symbol
    assign ahead = (t_count < s_count) ||
                   ((t_count == s_count) && (ctl.t_key < s_key));

    always_comb
    begin
        rank_next = rank_reg;
        if (ctl.start)
        begin
            rank_next = '0;
        end
        else if (ctl.sample && ahead)
        begin
            rank_next = rank_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    assign rank = rank_reg;

endmodule

`default_nettype wire

// ----- hdl/byte_histogram_sorted_unit.sv -----
// ----------------------------------------------------------------------------
// byte_histogram_sorted_unit
// byte frequency histogram with a rank-ordered list of the symbols seen
// ----------------------------------------------------------------------------
// A clear transaction completes in S_IDLE, and a count transaction reads the
// bin, then writes it back in the count memory (S_CNT_WR). A read transaction
// reads the sorted list and presents its result from S_RD_WAIT once the output
// register is free. For a finish transaction, for each nonzero bin the single
// read port of the count memory streams every bin past the rank unit once to
// find that symbol's place. The histogram clears through per-bin valid flags,
// so no clearing pass is needed after reset or clear. A result waits in an
// output register; count and clear transactions are still taken while it
// waits.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_histogram_sorted_unit #(
    parameter int COUNT_BITS  = 32,
    parameter int NUM_SYMBOLS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [bhs_pkg::ACTION_W-1:0]  action,
    input  logic [bhs_pkg::SYM_W-1:0]     symbol,
    input  logic [bhs_pkg::SYM_W-1:0]     rank,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [bhs_pkg::SYM_W-1:0]     out_symbol,
    output logic [bhs_pkg::FREQ_W-1:0]    frequency,
    output logic                          entry_valid,
    output logic [bhs_pkg::DIST_W-1:0]    distinct
);
    import bhs_pkg::*;

    localparam int                     SYM_AW    = $clog2(NUM_SYMBOLS);
    localparam int                     SRT_W     = SYM_W + COUNT_BITS;
    localparam logic [DIST_W-1:0]      NUM_SYM_D = DIST_W'(NUM_SYMBOLS);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CNT_WR  = 3'd1;
    localparam logic [2:0] S_RD_WAIT = 3'd2;
    localparam logic [2:0] S_SRC_RD  = 3'd3;
    localparam logic [2:0] S_SRC_CAP = 3'd4;
    localparam logic [2:0] S_SCAN    = 3'd5;
    localparam logic [2:0] S_PLACE   = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    // control registers
    logic [2:0]             state_reg,        state_next;
    logic [NUM_SYMBOLS-1:0] vbit_reg,         vbit_next;
    logic                   sorted_ready_reg, sorted_ready_next;
    logic [DIST_W-1:0]      distinct_reg,     distinct_next;
    logic [DIST_W-1:0]      dist_acc_reg,     dist_acc_next;
    logic [DIST_W-1:0]      outer_reg,        outer_next;
    logic [DIST_W-1:0]      scan_reg,         scan_next;
    logic                   p_valid_reg,      p_valid_next;
    logic                   result_valid_reg, result_valid_next;

    // payload registers
    logic [SYM_AW-1:0]      sym_reg,          sym_next;
    logic [SYM_W-1:0]       p_sym_reg,        p_sym_next;
    logic [COUNT_BITS-1:0]  cs_reg,           cs_next;
    logic                   rd_vbit_reg,      rd_vbit_next;
    logic                   rd_hit_reg,       rd_hit_next;
    logic [SYM_W-1:0]       out_symbol_reg,   out_symbol_next;
    logic [FREQ_W-1:0]      frequency_reg,    frequency_next;
    logic                   entry_valid_reg,  entry_valid_next;
    logic [DIST_W-1:0]      out_dist_reg,     out_dist_next;

    // memory ports
    logic                   cnt_rd_en,  cnt_wr_en;
    logic [SYM_AW-1:0]      cnt_rd_addr;
    logic [COUNT_BITS-1:0]  cnt_rd_data, cnt_wr_data, cnt_cur;
    logic                   srt_rd_en,  srt_wr_en;
    logic [SYM_AW-1:0]      srt_rd_addr, srt_wr_addr;
    logic [SRT_W-1:0]       srt_rd_data, srt_wr_data;

    // misc
    logic                   item_accept;
    logic                   out_free;
    logic [SYM_W-1:0]       src_sym;
    logic                   src_in_range;
    logic                   sym_in_range;
    logic                   rank_hit;
    logic [DIST_W-1:0]      rank_val;
    logic [COUNT_BITS-1:0]  srt_cnt;
    logic [FREQ_W-1:0]      srt_freq;
    scan_ctl_t              scan_ctl;

    // handshake
    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign out_free    = !result_valid_reg || !result_stall;

    // outer loop walks keys in signed-char order
    assign src_sym      = sym_key(outer_reg[SYM_W-1:0]);
    assign src_in_range = ({1'b0, src_sym} < NUM_SYM_D);
    assign sym_in_range = ({1'b0, symbol} < NUM_SYM_D);
    assign rank_hit     = sorted_ready_reg && ({1'b0, rank} < distinct_reg) &&
                          ({1'b0, rank} < NUM_SYM_D);

    // saturating bin increment, unwritten bins read as zero
    assign cnt_cur     = rd_vbit_reg ? cnt_rd_data : '0;
    assign cnt_wr_data = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

    // sorted entry holds symbol and its count
    assign srt_wr_addr = rank_val[SYM_AW-1:0];
    assign srt_wr_data = {src_sym, cs_reg};
    assign srt_cnt     = srt_rd_data[COUNT_BITS-1:0];

    // clamp the count into the frequency field
    generate
        if (COUNT_BITS > FREQ_W)
        begin : g_sat
            assign srt_freq = (|srt_cnt[COUNT_BITS-1:FREQ_W]) ? '1 : srt_cnt[FREQ_W-1:0];
        end
        else
        begin : g_ext
            assign srt_freq = FREQ_W'(srt_cnt);
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        vbit_next         = vbit_reg;
        sorted_ready_next = sorted_ready_reg;
        distinct_next     = distinct_reg;
        dist_acc_next     = dist_acc_reg;
        outer_next        = outer_reg;
        scan_next         = scan_reg;
        p_valid_next      = p_valid_reg;
        result_valid_next = result_valid_reg;
        sym_next          = sym_reg;
        p_sym_next        = p_sym_reg;
        cs_next           = cs_reg;
        rd_hit_next       = rd_hit_reg;
        out_symbol_next   = out_symbol_reg;
        frequency_next    = frequency_reg;
        entry_valid_next  = entry_valid_reg;
        out_dist_next     = out_dist_reg;
        cnt_rd_en         = 1'b0;
        cnt_rd_addr       = '0;
        cnt_wr_en         = 1'b0;
        srt_rd_en         = 1'b0;
        srt_rd_addr       = '0;
        srt_wr_en         = 1'b0;
        scan_ctl          = '0;

        // result taken downstream
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    case (action)
                        ACT_CLEAR:
                        begin
                            vbit_next         = '0;
                            distinct_next     = '0;
                            sorted_ready_next = 1'b0;
                        end
                        ACT_COUNT:
                        begin
                            if (sym_in_range)
                            begin
                                sorted_ready_next = 1'b0;
                                sym_next          = symbol[SYM_AW-1:0];
                                cnt_rd_en         = 1'b1;
                                cnt_rd_addr       = symbol[SYM_AW-1:0];
                                state_next        = S_CNT_WR;
                            end
                        end
                        ACT_FINISH:
                        begin
                            outer_next    = '0;
                            dist_acc_next = '0;
                            state_next    = S_SRC_RD;
                        end
                        ACT_READ:
                        begin
                            rd_hit_next = rank_hit;
                            srt_rd_en   = rank_hit;
                            srt_rd_addr = rank[SYM_AW-1:0];
                            state_next  = S_RD_WAIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // write back the incremented bin
            S_CNT_WR:
            begin
                cnt_wr_en         = 1'b1;
                vbit_next[sym_reg] = 1'b1;
                state_next        = S_IDLE;
            end

            // present the rank lookup
            S_RD_WAIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    out_symbol_next   = rd_hit_reg ? srt_rd_data[SRT_W-1 -: SYM_W] : '0;
                    frequency_next    = rd_hit_reg ? srt_freq : '0;
                    entry_valid_next  = rd_hit_reg;
                    out_dist_next     = sorted_ready_reg ? distinct_reg : '0;
                    state_next        = S_IDLE;
                end
            end

            // fetch the next symbol to place
            S_SRC_RD:
            begin
                if (outer_reg[DIST_W-1])
                begin
                    distinct_next     = dist_acc_reg;
                    sorted_ready_next = 1'b1;
                    state_next        = S_DONE;
                end
                else if (src_in_range)
                begin
                    cnt_rd_en   = 1'b1;
                    cnt_rd_addr = src_sym[SYM_AW-1:0];
                    state_next  = S_SRC_CAP;
                end
                else
                begin
                    outer_next = outer_reg + 1'b1;
                end
            end

            // empty bins are skipped, others start a rank scan
            S_SRC_CAP:
            begin
                if (rd_vbit_reg)
                begin
                    cs_next        = cnt_rd_data;
                    scan_next      = '0;
                    p_valid_next   = 1'b0;
                    scan_ctl.start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    outer_next = outer_reg + 1'b1;
                    state_next = S_SRC_RD;
                end
            end

            // stream every bin through the rank unit, one read per cycle
            S_SCAN:
            begin
                scan_ctl.sample = p_valid_reg && rd_vbit_reg;
                scan_ctl.t_key  = sym_key(p_sym_reg);
                if (scan_reg != NUM_SYM_D)
                begin
                    cnt_rd_en    = 1'b1;
                    cnt_rd_addr  = scan_reg[SYM_AW-1:0];
                    p_valid_next = 1'b1;
                    p_sym_next   = scan_reg[SYM_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                else
                begin
                    p_valid_next = 1'b0;
                    state_next   = S_PLACE;
                end
            end

            // store the symbol at its rank
            S_PLACE:
            begin
                srt_wr_en     = 1'b1;
                dist_acc_next = dist_acc_reg + 1'b1;
                outer_next    = outer_reg + 1'b1;
                state_next    = S_SRC_RD;
            end

            // finish result carries the distinct count only
            S_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    out_symbol_next   = '0;
                    frequency_next    = '0;
                    entry_valid_next  = 1'b0;
                    out_dist_next     = distinct_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // valid flag travels with each count memory read
    assign rd_vbit_next = cnt_rd_en ? vbit_reg[cnt_rd_addr] : rd_vbit_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vbit_reg         <= '0;
            sorted_ready_reg <= 1'b0;
            distinct_reg     <= '0;
            dist_acc_reg     <= '0;
            outer_reg        <= '0;
            scan_reg         <= '0;
            p_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            vbit_reg         <= vbit_next;
            sorted_ready_reg <= sorted_ready_next;
            distinct_reg     <= distinct_next;
            dist_acc_reg     <= dist_acc_next;
            outer_reg        <= outer_next;
            scan_reg         <= scan_next;
            p_valid_reg      <= p_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        sym_reg         <= sym_next;
        p_sym_reg       <= p_sym_next;
        cs_reg          <= cs_next;
        rd_vbit_reg     <= rd_vbit_next;
        rd_hit_reg      <= rd_hit_next;
        out_symbol_reg  <= out_symbol_next;
        frequency_reg   <= frequency_next;
        entry_valid_reg <= entry_valid_next;
        out_dist_reg    <= out_dist_next;
    end

    // histogram bins
    bhs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_SYMBOLS)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (sym_reg),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    // sorted symbol list
    bhs_ram #(
        .WIDTH (SRT_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_srt_ram (
        .clk     (clk),
        .wr_en   (srt_wr_en),
        .wr_addr (srt_wr_addr),
        .wr_data (srt_wr_data),
        .rd_en   (srt_rd_en),
        .rd_addr (srt_rd_addr),
        .rd_data (srt_rd_data)
    );

    // rank of the held symbol
    bhs_rank_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_rank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .t_count (cnt_rd_data),
        .s_count (cs_reg),
        .s_key   (outer_reg[SYM_W-1:0]),
        .rank    (rank_val)
    );

    // outputs
    assign result_valid = result_valid_reg;
    assign out_symbol   = out_symbol_reg;
    assign frequency    = frequency_reg;
    assign entry_valid  = entry_valid_reg;
    assign distinct     = out_dist_reg;

endmodule

`default_nettype wire

// ----- hdl/bhs_checker.sv -----
// ----------------------------------------------------------------------------
// bhs_checker
// port-level checks on the byte histogram sorted unit, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_histogram_sorted_unit_assert.svh"

module bhs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_stall,
    input logic [bhs_pkg::ACTION_W-1:0]  action,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [bhs_pkg::SYM_W-1:0]     out_symbol,
    input logic [bhs_pkg::FREQ_W-1:0]    frequency,
    input logic                          entry_valid,
    input logic [bhs_pkg::DIST_W-1:0]    distinct
);
    import bhs_pkg::*;

    logic quiet_accept;

    // clear or count transaction taken with no result pending
    assign quiet_accept = item_valid && !item_stall && !result_valid &&
                          ((action == ACT_CLEAR) || (action == ACT_COUNT));

    // stalled result holds
    `BHS_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(out_symbol) && $stable(frequency) && $stable(entry_valid) && $stable(distinct), "stalled result changed")

    // a valid entry implies a nonempty sorted list
    `BHS_ASSERT_IMP(a_entry_distinct, result_valid && entry_valid, distinct != '0, "valid entry with no distinct symbols")

    // an invalid entry carries zero symbol and frequency
    `BHS_ASSERT_IMP(a_entry_zero, result_valid && !entry_valid, (out_symbol == '0) && (frequency == '0), "invalid entry with nonzero payload")

    // clear and count never produce a result
    `BHS_ASSERT_NXT(a_no_result, quiet_accept, !result_valid, "result after clear or count")

endmodule

bind byte_histogram_sorted_unit bhs_checker u_bhs_checker (.*);

`default_nettype wire

// ----- tb/tb_byte_histogram_sorted_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_histogram_sorted_unit
// self-checking bench for the byte histogram with rank-ordered readout.
// A short table of directed transactions covers these cases: reads after
// reset, empty finish, tie order across the signed-char boundary, out of
// range ranks, rebuilds and clear. It is followed by random histogram sets:
// clear, skewed counts, finish and rank reads, with some noise mixed in.
// Every reply is compared with an in-bench predictor, or for fixed directed
// rows with the table's reply. The run steps through four handshake pressure phases.
// ----------------------------------------------------------------------------

module tb_byte_histogram_sorted_unit;

    import bhs_pkg::*;

    localparam int NUM_BINS     = 256;
    localparam int TARGET_OPS   = 1800;
    localparam int DRAIN_CYCLES = 16;

    // one reply transaction
    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [FREQ_W-1:0] freq;
        logic              hit;
        logic [DIST_W-1:0] n_distinct;
    } hist_entry_t;

    // one row of the directed table; fixed rows carry their reply inline
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [SYM_W-1:0]    sym;
        logic [SYM_W-1:0]    rnk;
        logic                fixed;
        hist_entry_t         want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam stim_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        '{ACT_READ,   8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd0}},
        '{ACT_FINISH, 8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd0}},
        '{ACT_READ,   8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd0}},
        '{ACT_COUNT,  8'h00, 8'hff, 1'b0, '0},
        '{ACT_COUNT,  8'hff, 8'h00, 1'b0, '0},
        '{ACT_COUNT,  8'h7f, 8'h80, 1'b0, '0},
        '{ACT_COUNT,  8'h80, 8'h7f, 1'b0, '0},
        '{ACT_COUNT,  8'h00, 8'h00, 1'b0, '0},
        '{ACT_READ,   8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd0}},
        '{ACT_FINISH, 8'hff, 8'hff, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd4}},
        '{ACT_READ,   8'h00, 8'h00, 1'b0, '0},
        '{ACT_READ,   8'h00, 8'h01, 1'b0, '0},
        '{ACT_READ,   8'h00, 8'h02, 1'b0, '0},
        '{ACT_READ,   8'h00, 8'h03, 1'b0, '0},
        '{ACT_READ,   8'h00, 8'h04, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd4}},
        '{ACT_READ,   8'hff, 8'hff, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd4}},
        '{ACT_COUNT,  8'h55, 8'haa, 1'b0, '0},
        '{ACT_READ,   8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd0}},
        '{ACT_FINISH, 8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd5}},
        '{ACT_FINISH, 8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd5}},
        '{ACT_READ,   8'h00, 8'h04, 1'b0, '0},
        '{ACT_CLEAR,  8'hff, 8'hff, 1'b0, '0},
        '{ACT_READ,   8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd0}},
        '{ACT_FINISH, 8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd0}}
    };

    // clock, reset and dut ports
    logic                clk;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic [ACTION_W-1:0] action       = ACT_CLEAR;
    logic [SYM_W-1:0]    symbol       = '0;
    logic [SYM_W-1:0]    rank         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [SYM_W-1:0]    out_symbol;
    logic [FREQ_W-1:0]   frequency;
    logic                entry_valid;
    logic [DIST_W-1:0]   distinct;

    // predictor state
    logic [FREQ_W-1:0]   bin_tally [NUM_BINS] = '{default: '0};
    logic [SYM_W-1:0]    rank_order [NUM_BINS];
    logic [DIST_W-1:0]   seen_count  = '0;
    logic                order_valid = 1'b0;

    hist_entry_t         replies_due [$];
    int                  ops_accepted    = 0;
    int                  fail_count      = 0;
    int                  op_idle_pct     = 0;
    int                  reply_stall_pct = 0;

    byte_histogram_sorted_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .symbol       (symbol),
        .rank         (rank),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_symbol   (out_symbol),
        .frequency    (frequency),
        .entry_valid  (entry_valid),
        .distinct     (distinct)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // histogram predictor: updates state, returns the reply if one is due
    task automatic apply_histogram_op(input logic [ACTION_W-1:0] act,
                                      input logic [SYM_W-1:0] sym,
                                      input logic [SYM_W-1:0] rnk,
                                      output bit has_reply,
                                      output hist_entry_t reply);
        int               placed;
        int               slot;
        logic [SYM_W-1:0] key_sym;
        reply     = '0;
        has_reply = 1'b0;
        case (act)
            ACT_CLEAR:
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
                seen_count  = '0;
                order_valid = 1'b0;
            end
            ACT_COUNT:
            begin
                if (bin_tally[sym] != '1)
                    bin_tally[sym] = bin_tally[sym] + 1'b1;
                order_valid = 1'b0;
            end
            ACT_FINISH:
            begin
                // walk in signed-char order, insert after equal counts
                placed = 0;
                for (int i = 0; i < NUM_BINS; i++)
                begin
                    key_sym = SYM_W'(i) ^ KEY_FLIP;
                    if (bin_tally[key_sym] != '0)
                    begin
                        slot = placed;
                        while (slot > 0 && bin_tally[rank_order[slot-1]] > bin_tally[key_sym])
                        begin
                            rank_order[slot] = rank_order[slot-1];
                            slot--;
                        end
                        rank_order[slot] = key_sym;
                        placed++;
                    end
                end
                seen_count       = DIST_W'(placed);
                order_valid      = 1'b1;
                has_reply        = 1'b1;
                reply.n_distinct = seen_count;
            end
            default:
            begin
                has_reply        = 1'b1;
                reply.n_distinct = order_valid ? seen_count : '0;
                if (order_valid && DIST_W'(rnk) < seen_count)
                begin
                    reply.sym  = rank_order[rnk];
                    reply.freq = bin_tally[rank_order[rnk]];
                    reply.hit  = 1'b1;
                end
            end
        endcase
    endtask

    // drive one transaction, hold it through stalls, predict on acceptance
    task automatic send_op(input logic [ACTION_W-1:0] act,
                           input logic [SYM_W-1:0] sym,
                           input logic [SYM_W-1:0] rnk,
                           input bit fixed,
                           input hist_entry_t fixed_reply);
        bit          taken;
        bit          has_reply;
        hist_entry_t reply;
        while ($urandom_range(99) < op_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        action     <= act;
        symbol     <= sym;
        rank       <= rnk;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end
        apply_histogram_op(act, sym, rnk, has_reply, reply);
        if (has_reply)
            replies_due.insert(replies_due.size(), fixed ? fixed_reply : reply);
        ops_accepted++;
    endtask

    // random actions with random fields
    task automatic send_noise(input int n);
        logic [ACTION_W-1:0] act;
        for (int k = 0; k < n; k++)
        begin
            act = ACTION_W'($urandom_range(3));
            send_op(act, SYM_W'($urandom), SYM_W'($urandom), 1'b0, '0);
        end
    endtask

    // usually clear, skewed counts over a symbol pool, finish, then rank reads
    task automatic send_symbol_set(input int width, input int extra, input bit full_set);
        logic [SYM_W-1:0] pool [$];
        logic [SYM_W-1:0] mask;
        logic [SYM_W-1:0] rnk;
        int               pick;
        int               reads;
        mask = SYM_W'($urandom);
        if (full_set || $urandom_range(9) != 0)
            send_op(ACT_CLEAR, SYM_W'($urandom), SYM_W'($urandom), 1'b0, '0);
        if (full_set)
        begin
            // every symbol once, in a permuted order
            for (int i = 0; i < NUM_BINS; i++)
            begin
                pool.insert(pool.size(), SYM_W'(i) ^ mask);
                send_op(ACT_COUNT, SYM_W'(i) ^ mask, SYM_W'($urandom), 1'b0, '0);
            end
        end
        else
        begin
            for (int i = 0; i < width; i++)
                pool.insert(pool.size(), SYM_W'($urandom));
        end
        // bias toward the front of the pool so counts differ
        for (int i = 0; i < extra; i++)
        begin
            pick = $urandom_range($urandom_range(pool.size() - 1));
            send_op(ACT_COUNT, pool[pick], SYM_W'($urandom), 1'b0, '0);
        end
        send_op(ACT_FINISH, SYM_W'($urandom), SYM_W'($urandom), 1'b0, '0);
        reads = full_set ? 40 : $urandom_range(2, 8);
        for (int i = 0; i < reads; i++)
        begin
            // a stray count now and then invalidates the list
            if ($urandom_range(19) == 0)
                send_op(ACT_COUNT, pool[$urandom_range(pool.size() - 1)], '0, 1'b0, '0);
            if (full_set && i == 0)
                rnk = 8'hff;
            else if (seen_count != '0 && $urandom_range(4) != 0)
                rnk = SYM_W'($urandom_range(seen_count - 1));
            else
                rnk = SYM_W'($urandom);
            send_op(ACT_READ, SYM_W'($urandom), rnk, 1'b0, '0);
        end
    endtask

    // receiver stall pattern
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < reply_stall_pct);

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // reply check, sampled mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin : reply_check
        hist_entry_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, actual %0h/%0h/%0h/%0h",
                         $time, out_symbol, frequency, entry_valid, distinct);
                fail_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("out_symbol",  32'(want.sym),        32'(out_symbol));
                check_field("frequency",   want.freq,            frequency);
                check_field("entry_valid", 32'(want.hit),        32'(entry_valid));
                check_field("distinct",    32'(want.n_distinct), 32'(distinct));
            end
        end
    end

    // run limit, well above the slowest legal run
    initial
    begin
        #100_000_000;
        $display("byte_histogram_sorted_unit regression: fail");
        $finish;
    end

    // main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int n = 0; n < DIRECTED_ROWS; n++)
            send_op(DIRECTED_TABLE[n].act, DIRECTED_TABLE[n].sym, DIRECTED_TABLE[n].rnk,
                    DIRECTED_TABLE[n].fixed, DIRECTED_TABLE[n].want);

        // random sets across the pressure phases
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin op_idle_pct = 0;  reply_stall_pct = 0;  end
                1:       begin op_idle_pct = 61; reply_stall_pct = 0;  end
                2:       begin op_idle_pct = 0;  reply_stall_pct = 61; end
                default: begin op_idle_pct = 8;  reply_stall_pct = 8;  end
            endcase
            // one set over the whole alphabet
            if (ph == 3)
                send_symbol_set(NUM_BINS, 48, 1'b1);
            while (ops_accepted < DIRECTED_ROWS + (ph + 1) * TARGET_OPS / 4)
            begin
                if ($urandom_range(99) < 15)
                    send_noise($urandom_range(3, 12));
                else
                    send_symbol_set($urandom_range(1, 12), $urandom_range(1, 30), 1'b0);
            end
        end
        item_valid <= 1'b0;

        // drain
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("byte_histogram_sorted_unit regression: pass");
        else
            $display("byte_histogram_sorted_unit regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bhs_pkg.sv
hdl/bhs_ram.sv
hdl/bhs_rank_unit.sv
hdl/byte_histogram_sorted_unit.sv
hdl/bhs_checker.sv
tb/tb_byte_histogram_sorted_unit.sv
